>>> design/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg: shared types and constants of the NEC IR pulse decoder
// Payload structs of the request and result channels, the register map,
// reset values of the control registers and the pulse-width windows.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

   // Field widths
   localparam int PULSE_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int TICK_W   = 4;
   localparam int WORD_W   = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Request payload: one timer event
   typedef struct packed {
      logic               overflow_tick;
      logic               edge_captured;
      logic               pin_level;
      logic [PULSE_W-1:0] pulse_width;
   } req_payload_type;

   // Result payload: decoded key and repeat count
   typedef struct packed {
      logic [BYTE_W-1:0] key_code;
      logic [BYTE_W-1:0] repeat_count;
   } rsp_payload_type;

   // Control register values handed to the decoder core
   typedef struct packed {
      logic [BYTE_W-1:0] addr_high;
      logic [BYTE_W-1:0] addr_low;
      logic [TICK_W-1:0] timeout;
   } cfg_type;

   // Register map (word index = paddr[3:2])
   typedef enum logic [1:0] {
      CSR_ADDR_HIGH = 2'd0,
      CSR_ADDR_LOW  = 2'd1,
      CSR_TIMEOUT   = 2'd2
   } csr_index_type;

   localparam logic [BYTE_W-1:0] ADDR_HIGH_RESET = 8'h33;
   localparam logic [BYTE_W-1:0] ADDR_LOW_RESET  = 8'hB8;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 4'd14;

   // High-time windows in microseconds, bounds exclusive
   localparam logic [PULSE_W-1:0] BIT0_MIN   = 16'd300;
   localparam logic [PULSE_W-1:0] BIT0_MAX   = 16'd800;
   localparam logic [PULSE_W-1:0] BIT1_MIN   = 16'd1400;
   localparam logic [PULSE_W-1:0] BIT1_MAX   = 16'd1800;
   localparam logic [PULSE_W-1:0] REPEAT_MIN = 16'd2200;
   localparam logic [PULSE_W-1:0] REPEAT_MAX = 16'd2600;
   localparam logic [PULSE_W-1:0] LEADER_MIN = 16'd4200;
   localparam logic [PULSE_W-1:0] LEADER_MAX = 16'd4700;

endpackage

`default_nettype wire

>>> design/necir_stream_if.sv
// ----------------------------------------------------------------------------
// necir_stream_if: valid/ready channel
// Carries one request or result payload per handshake; the payload type is
// set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface necir_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/necir_csr.sv
// ----------------------------------------------------------------------------
// necir_csr: control register block
// APB-style write and read of the expected address bytes and the leader
// timeout; presents the current values to the decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_csr
   import necir_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_ADDR_HIGH: cfg_in.addr_high = csr_pwdata[BYTE_W-1:0];
            CSR_ADDR_LOW:  cfg_in.addr_low  = csr_pwdata[BYTE_W-1:0];
            CSR_TIMEOUT:   cfg_in.timeout   = csr_pwdata[TICK_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_high <= ADDR_HIGH_RESET;
         cfg_ff.addr_low  <= ADDR_LOW_RESET;
         cfg_ff.timeout   <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      case (index)
         CSR_ADDR_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.addr_high);
         CSR_ADDR_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.addr_low);
         CSR_TIMEOUT:   csr_prdata = CSR_DATA_W'(cfg_ff.timeout);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> design/necir_core.sv
// ----------------------------------------------------------------------------
// necir_core: decoder datapath
// Input register, one pass of tick, edge and frame-check logic over the
// decoder state, and a result register towards the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_core
   import necir_pkg::*;
#(
   parameter int CAPTURE_BITS = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   necir_stream_if.sink   req,
   necir_stream_if.source rsp
);

   localparam logic [PULSE_W-1:0] CAP_MASK = (CAPTURE_BITS >= PULSE_W) ? {PULSE_W{1'b1}} :
      PULSE_W'((32'd1 << CAPTURE_BITS) - 32'd1);

   // Pipeline registers
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // Decoder state
   logic              leader_seen_ff, leader_seen_in;
   logic              frame_done_ff,  frame_done_in;
   logic              rise_seen_ff,   rise_seen_in;
   logic [TICK_W-1:0] tick_count_ff,  tick_count_in;
   logic [WORD_W-1:0] shift_word_ff,  shift_word_in;
   logic [BYTE_W-1:0] repeats_ff,     repeats_in;
   logic [BYTE_W-1:0] key_in;

   logic advance;
   logic fire;
   logic req_fire;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req.payload;
      end
   end

   // Tick, edge and frame check in one pass
   always_comb begin
      logic [PULSE_W-1:0] t;
      logic [BYTE_W-1:0]  cmd;
      logic [BYTE_W-1:0]  inv;
      t   = in_data_ff.pulse_width & CAP_MASK;
      cmd = '0;
      inv = '0;

      leader_seen_in = leader_seen_ff;
      frame_done_in  = frame_done_ff;
      rise_seen_in   = rise_seen_ff;
      tick_count_in  = tick_count_ff;
      shift_word_in  = shift_word_ff;
      repeats_in     = repeats_ff;
      key_in         = '0;

      // Overflow tick: end of frame and leader timeout
      if (in_data_ff.overflow_tick && leader_seen_in) begin
         rise_seen_in = 1'b0;
         if (tick_count_in == '0) begin
            frame_done_in = 1'b1;
         end
         if (tick_count_in < cfg.timeout) begin
            tick_count_in = tick_count_in + TICK_W'(1);
         end else begin
            leader_seen_in = 1'b0;
            tick_count_in  = '0;
         end
      end

      // Captured edge: mark the rise, classify the high time on the fall
      if (in_data_ff.edge_captured) begin
         if (in_data_ff.pin_level) begin
            rise_seen_in = 1'b1;
         end else begin
            if (rise_seen_in) begin
               if (leader_seen_in) begin
                  if (t > BIT0_MIN && t < BIT0_MAX) begin
                     shift_word_in = {shift_word_in[WORD_W-2:0], 1'b0};
                  end else if (t > BIT1_MIN && t < BIT1_MAX) begin
                     shift_word_in = {shift_word_in[WORD_W-2:0], 1'b1};
                  end else if (t > REPEAT_MIN && t < REPEAT_MAX) begin
                     repeats_in    = repeats_in + BYTE_W'(1);
                     tick_count_in = '0;
                  end
               end else if (t > LEADER_MIN && t < LEADER_MAX) begin
                  leader_seen_in = 1'b1;
                  repeats_in     = '0;
               end
            end
            rise_seen_in = 1'b0;
         end
      end

      // Frame check: address bytes and command against its complement
      if (frame_done_in) begin
         cmd = shift_word_in[15:8];
         inv = shift_word_in[7:0];
         if (shift_word_in[31:24] == cfg.addr_high && shift_word_in[23:16] == cfg.addr_low &&
             cmd == ~inv) begin
            key_in = cmd;
         end
         if (key_in == '0 || !leader_seen_in) begin
            frame_done_in = 1'b0;
            repeats_in    = '0;
         end
      end
   end

   // Advance state on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         leader_seen_ff <= 1'b0;
         frame_done_ff  <= 1'b0;
         rise_seen_ff   <= 1'b0;
         tick_count_ff  <= '0;
         shift_word_ff  <= '0;
         repeats_ff     <= '0;
      end else if (fire) begin
         leader_seen_ff <= leader_seen_in;
         frame_done_ff  <= frame_done_in;
         rise_seen_ff   <= rise_seen_in;
         tick_count_ff  <= tick_count_in;
         shift_word_ff  <= shift_word_in;
         repeats_ff     <= repeats_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff.key_code     <= key_in;
         rsp_data_ff.repeat_count <= repeats_in;
      end
   end

   // Tick counter only runs while a leader is held
   a_tick_idle: assert property (@(posedge clock) disable iff (reset)
      !leader_seen_ff |-> tick_count_ff == '0)
      else $error("tick counter running without a leader");

   // Reported repeat count is the state left by that request
   a_repeat_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && rsp_data_ff.repeat_count == repeats_ff)
      else $error("repeat count out of step with state");

   // A key is only reported for a frame whose address matched
   a_key_addr: assert property (@(posedge clock) disable iff (reset)
      fire && key_in != '0 |=> rsp_data_ff.key_code == shift_word_ff[15:8] &&
         shift_word_ff[31:24] == $past(cfg.addr_high))
      else $error("key reported without a matching frame");

endmodule

`default_nettype wire

>>> design/nec_ir_pulse_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder: NEC-style infrared remote decoder
// Takes timer events (overflow tick, captured edge with pin level and high
// time), decodes leader, data bits and repeat codes, and returns the
// validated command byte and repeat count for every event.
//
//   Channel  Direction  Handshake              Payload
//   req_if   in         valid/ready            overflow_tick, edge_captured,
//                                              pin_level, pulse_width
//   rsp_if   out        valid/ready            key_code, repeat_count
//   csr_*    in/out     APB-style, pready = 1  address bytes, timeout
//
// One request a cycle is accepted while rsp_if is not stalled; each passes
// from the input register through a single pass of tick, edge and check
// logic into the result register, from which its result is presented.
// Reset is synchronous: it clears decoder state and presets the control registers.
// A stalled result holds in the result register while one further request
// is taken into the input register; beyond that req_if.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_pulse_decoder
   import necir_pkg::*;
#(
   parameter int CAPTURE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   necir_stream_if.sink               req_if,
   necir_stream_if.source             rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type cfg;

   // Control registers
   necir_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Decoder datapath
   necir_core #(
      .CAPTURE_BITS (CAPTURE_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_if),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire

>>> tb/sv/nec_ir_pulse_decoder_tb.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_tb: self-checking testbench of the NEC IR decoder
// Feeds timer events (ticks, rising and falling edges with high times) as
// whole frames, repeat codes, timeouts and noise, under several register
// settings, with random gaps and stalls on both channels. A cycle-free model
// of the decoder predicts key and repeat count for every request; each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_pulse_decoder_tb;
   import necir_pkg::*;

   localparam int CAPTURE_BITS     = 16;
   localparam logic [15:0] CAPTURE_MASK = 16'((32'd1 << CAPTURE_BITS) - 1);
   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 7;
   localparam int LIMIT_CYCLES     = 500000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int PHASES           = 6;
   localparam int PHASE_ITEMS      = 115;
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int MAX_REPORTS      = 10;

   // High-time windows in microseconds, bounds excluded
   localparam int ZERO_LO   = 300;
   localparam int ZERO_HI   = 800;
   localparam int ONE_LO    = 1400;
   localparam int ONE_HI    = 1800;
   localparam int RPT_LO    = 2200;
   localparam int RPT_HI    = 2600;
   localparam int LEADER_LO = 4200;
   localparam int LEADER_HI = 4700;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   necir_stream_if #(.payload_type(req_payload_type)) req_chan ();
   necir_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   nec_ir_pulse_decoder #(
      .CAPTURE_BITS(CAPTURE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_chan),
      .rsp_if     (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Decoder model: register copies and state
   logic [7:0]  want_addr_high = ADDR_HIGH_RESET;
   logic [7:0]  want_addr_low  = ADDR_LOW_RESET;
   logic [3:0]  tick_limit     = TIMEOUT_RESET;
   logic        in_frame       = 1'b0;
   logic        frame_ready    = 1'b0;
   logic        rise_pending   = 1'b0;
   logic [3:0]  tick_run       = 4'd0;
   logic [31:0] bit_word       = 32'd0;
   logic [7:0]  repeat_tally   = 8'd0;

   req_payload_type pending_events [$];
   rsp_payload_type expected_keys [$];
   rsp_payload_type want;

   int stim_total  = 0;
   int req_total   = 0;
   int rsp_total   = 0;
   int error_count = 0;
   int req_gap     = 0;
   int rsp_wait    = 0;
   int rsp_hold    = 0;
   logic req_burst = 1'b0;
   logic rsp_burst = 1'b0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   int window_bounds [8] = '{ZERO_LO, ZERO_HI, ONE_LO, ONE_HI,
                             RPT_LO, RPT_HI, LEADER_LO, LEADER_HI};

   // Apply one timer event to the model and return the key and repeat count
   function automatic rsp_payload_type decode_event(input req_payload_type ev);
      rsp_payload_type res;
      logic [15:0]     hi_time;
      logic [7:0]      key;
      hi_time = ev.pulse_width & CAPTURE_MASK;
      key     = 8'd0;
      // tick first: end of frame, then count towards the timeout
      if (ev.overflow_tick && in_frame) begin
         rise_pending = 1'b0;
         if (tick_run == 4'd0)
            frame_ready = 1'b1;
         if (tick_run < tick_limit) begin
            tick_run = tick_run + 4'd1;
         end else begin
            in_frame = 1'b0;
            tick_run = 4'd0;
         end
      end
      // then the edge: classify the high time on a falling edge
      if (ev.edge_captured) begin
         if (ev.pin_level) begin
            rise_pending = 1'b1;
         end else begin
            if (rise_pending) begin
               if (in_frame) begin
                  if (hi_time > ZERO_LO && hi_time < ZERO_HI) begin
                     bit_word = bit_word << 1;
                  end else if (hi_time > ONE_LO && hi_time < ONE_HI) begin
                     bit_word = (bit_word << 1) | 32'd1;
                  end else if (hi_time > RPT_LO && hi_time < RPT_HI) begin
                     repeat_tally = repeat_tally + 8'd1;
                     tick_run     = 4'd0;
                  end
               end else if (hi_time > LEADER_LO && hi_time < LEADER_HI) begin
                  in_frame     = 1'b1;
                  repeat_tally = 8'd0;
               end
            end
            rise_pending = 1'b0;
         end
      end
      // validate address bytes and command against its complement
      if (frame_ready) begin
         if (bit_word[31:24] == want_addr_high && bit_word[23:16] == want_addr_low &&
             bit_word[15:8] == ~bit_word[7:0])
            key = bit_word[15:8];
         if (key == 8'd0 || !in_frame) begin
            frame_ready  = 1'b0;
            repeat_tally = 8'd0;
         end
      end
      res.key_code     = key;
      res.repeat_count = repeat_tally;
      return res;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("FAIL nec_ir_pulse_decoder");
      $finish;
   end

   // Request driver: hold until taken, then wait the drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_gap > 0) begin
            req_chan.valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_events.size() > 0) begin
            req_chan.payload <= pending_events.pop_front();
            req_chan.valid   <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 19);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, one long hold-off early in the run
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = 0;
         rsp_hold = 0;
      end else begin
         if (rsp_taken) begin
            if (rsp_total == LONG_HOLD_AT)
               rsp_hold = LONG_HOLD_CYCLES;
            if ($urandom_range(0, 39) == 0)
               rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 19);
         end
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else if (rsp_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         rsp_taken <= rsp_chan.valid && rsp_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            expected_keys.push_back(decode_event(req_chan.payload));
            req_total = req_total + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_total = rsp_total + 1;
            if (expected_keys.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: result with no request outstanding: key %0d repeats %0d",
                           $time, rsp_chan.payload.key_code, rsp_chan.payload.repeat_count);
               error_count = error_count + 1;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_chan.payload.key_code !== want.key_code ||
                   rsp_chan.payload.repeat_count !== want.repeat_count) begin
                  if (error_count < MAX_REPORTS)
                     $display("%0t: result %0d: expected key %0d repeats %0d, got key %0d repeats %0d",
                              $time, rsp_total, want.key_code, want.repeat_count,
                              rsp_chan.payload.key_code, rsp_chan.payload.repeat_count);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // Register write: setup then access cycle, and mirror into the model
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_ADDR_HIGH: want_addr_high = value[7:0];
         CSR_ADDR_LOW:  want_addr_low  = value[7:0];
         CSR_TIMEOUT:   tick_limit     = value[3:0];
         default: ;
      endcase
   endtask

   task automatic queue_event(input logic tick, input logic cap, input logic pin,
                              input logic [15:0] width);
      req_payload_type ev;
      ev.overflow_tick = tick;
      ev.edge_captured = cap;
      ev.pin_level     = pin;
      ev.pulse_width   = width;
      pending_events.push_back(ev);
      stim_total = stim_total + 1;
   endtask

   // Rising edge, then falling edge carrying the high time
   task automatic queue_pulse(input logic [15:0] width);
      queue_event(1'b0, 1'b1, 1'b1, 16'($urandom_range(0, 65535)));
      queue_event(1'b0, 1'b1, 1'b0, width);
   endtask

   // Leader and 32 data bits, first bit ending up in the top of the word
   task automatic queue_frame(input logic [31:0] word, input logic clean);
      queue_pulse(16'($urandom_range(LEADER_LO + 1, LEADER_HI - 1)));
      for (int i = 31; i >= 0; i--) begin
         if (!clean && $urandom_range(0, 49) == 0)
            queue_event(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)),
                        16'($urandom));
         else if (word[i])
            queue_pulse(16'($urandom_range(ONE_LO + 1, ONE_HI - 1)));
         else
            queue_pulse(16'($urandom_range(ZERO_LO + 1, ZERO_HI - 1)));
      end
   endtask

   task automatic queue_tick();
      queue_event(1'b1, 1'b0, 1'($urandom_range(0, 1)), 16'($urandom));
   endtask

   // Wait until every request is taken and every result checked
   task automatic wait_idle();
      while (!(req_total == stim_total && expected_keys.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      int         start;
      int         n;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] cmd;
      logic [7:0] inv;
      logic [3:0] lim;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            // sender pauses here until the decoder has drained
            wait_idle();
            case (ph)
               1: begin hi = 8'h00; lo = 8'h00; lim = 4'd1; end
               2: begin hi = 8'hFF; lo = 8'hFF; lim = 4'd15; end
               3: begin
                  hi  = 8'($urandom_range(0, 255));
                  lo  = 8'($urandom_range(0, 255));
                  lim = 4'($urandom_range(1, 15));
               end
               4: begin hi = 8'h33; lo = 8'hB8; lim = 4'd0; end
               default: begin
                  hi  = 8'($urandom_range(0, 255));
                  lo  = 8'($urandom_range(0, 255));
                  lim = 4'($urandom_range(2, 5));
               end
            endcase
            csr_write(CSR_ADDR_HIGH, {24'd0, hi});
            csr_write(CSR_ADDR_LOW, {24'd0, lo});
            csr_write(CSR_TIMEOUT, {28'd0, lim});
         end

         if (ph == 0) begin
            // directed: corner events and each class of high time
            queue_event(1'b1, 1'b0, 1'b0, 16'd0);        // tick with no leader
            queue_event(1'b0, 1'b0, 1'b1, 16'hFFFF);     // empty event
            queue_event(1'b0, 1'b1, 1'b0, 16'd4500);     // fall with no rise before
            queue_pulse(16'd4200);                       // leader bound, excluded
            queue_pulse(16'd4699);                       // leader
            queue_pulse(16'hFFFF);                       // outside every window
            queue_pulse(16'd301);                        // 0 bit
            queue_pulse(16'd1799);                       // 1 bit
            queue_pulse(16'd2201);                       // repeat
            queue_event(1'b1, 1'b1, 1'b1, 16'd0);        // tick and rise together
            queue_event(1'b1, 1'b1, 1'b0, 16'd1500);     // tick and fall together
            queue_event(1'b1, 1'b0, 1'b0, 16'd0);        // tick with the leader held
         end

         if (ph == 2) begin
            // valid frame then a long run of repeats so the count wraps
            cmd = 8'($urandom_range(1, 255));
            queue_frame({want_addr_high, want_addr_low, cmd, ~cmd}, 1'b1);
            queue_tick();
            repeat (260)
               queue_pulse(16'($urandom_range(RPT_LO + 1, RPT_HI - 1)));
            repeat (17) queue_tick();
         end

         start = stim_total;
         while (stim_total - start < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  // frame with mostly matching address, then repeats and ticks
                  hi  = ($urandom_range(0, 3) != 0) ? want_addr_high : 8'($urandom);
                  lo  = ($urandom_range(0, 3) != 0) ? want_addr_low : 8'($urandom);
                  cmd = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
                  inv = ($urandom_range(0, 3) != 0) ? ~cmd : 8'($urandom);
                  queue_frame({hi, lo, cmd, inv}, 1'($urandom_range(0, 1)));
                  queue_tick();
                  n = $urandom_range(0, 4);
                  repeat (n) begin
                     queue_pulse(16'($urandom_range(RPT_LO + 1, RPT_HI - 1)));
                     repeat ($urandom_range(1, 3)) queue_tick();
                  end
                  repeat ($urandom_range(0, int'(tick_limit) + 2)) queue_tick();
               end
               5: begin
                  // truncated frame
                  queue_pulse(16'($urandom_range(LEADER_LO + 1, LEADER_HI - 1)));
                  repeat ($urandom_range(1, 31))
                     queue_pulse($urandom_range(0, 1) ?
                                 16'($urandom_range(ONE_LO + 1, ONE_HI - 1)) :
                                 16'($urandom_range(ZERO_LO + 1, ZERO_HI - 1)));
                  queue_tick();
               end
               6: begin
                  // run of ticks, some with an edge on the same event
                  repeat ($urandom_range(1, 18))
                     queue_event(1'b1, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                                 16'($urandom));
               end
               7: begin
                  // noise
                  repeat ($urandom_range(1, 10))
                     queue_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 16'($urandom));
               end
               8: begin
                  // high times on and next to the window bounds
                  if ($urandom_range(0, 1))
                     queue_pulse(16'($urandom_range(LEADER_LO + 1, LEADER_HI - 1)));
                  repeat ($urandom_range(1, 6))
                     queue_pulse(16'(window_bounds[$urandom_range(0, 7)] +
                                     $urandom_range(0, 2) - 1));
                  if ($urandom_range(0, 1))
                     queue_tick();
               end
               default: begin
                  // leader followed by repeat codes
                  queue_pulse(16'($urandom_range(LEADER_LO + 1, LEADER_HI - 1)));
                  repeat ($urandom_range(1, 6)) begin
                     queue_pulse(16'($urandom_range(RPT_LO + 1, RPT_HI - 1)));
                     if ($urandom_range(0, 1))
                        queue_tick();
                  end
               end
            endcase
         end
      end

      wait_idle();
      if (error_count == 0 && expected_keys.size() == 0) begin
         $display("PASS nec_ir_pulse_decoder");
      end else begin
         $display("FAIL nec_ir_pulse_decoder");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
design/necir_pkg.sv
design/necir_stream_if.sv
design/necir_csr.sv
design/necir_core.sv
design/nec_ir_pulse_decoder.sv
tb/sv/nec_ir_pulse_decoder_tb.sv
